[hw/rtl/bsmw_pkg.sv]
// ----------------------------------------------------------------------------
// bsmw_pkg
// Shared types and constants for the multi-width byte stack.
// ----------------------------------------------------------------------------
package bsmw_pkg;

    localparam int LANES     = 8;   // byte lanes, one per byte of the widest element
    localparam int POS_W     = 8;   // byte position width (positions 0..255)
    localparam int SIZE_W    = 4;   // element size in bytes, 1..8
    localparam int FILL_OUT_W = 7;

    typedef enum logic [2:0] {
        CMD_PUSH       = 3'd0,
        CMD_POP        = 3'd1,
        CMD_PEEK_LAST  = 3'd2,
        CMD_PEEK_FIRST = 3'd3,
        CMD_CLEAR      = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Per-request lane access, broadcast to all byte lanes
    typedef struct packed {
        logic                en;
        logic                we;
        logic [POS_W-1:0]    base;
        logic [SIZE_W-1:0]   n;
    } bsmw_acc_t;

endpackage

[hw/rtl/bsmw_ram.sv]
// ----------------------------------------------------------------------------
// bsmw_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bsmw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/bsmw_lane.sv]
// ----------------------------------------------------------------------------
// bsmw_lane
// One byte lane: holds every byte whose position is LANE modulo 8.
// ----------------------------------------------------------------------------
module bsmw_lane
    import bsmw_pkg::*;
#(
    parameter int LANE = 0,
    parameter int ROWS = 8
) (
    input  logic              clk,
    input  bsmw_acc_t         acc,
    input  logic [63:0]       push_value,
    output logic [7:0]        lane_byte
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [2:0] LANE_ID = 3'(LANE);

    logic [2:0]       ofs;
    logic             active;
    logic [POS_W:0]   pos;
    logic [POS_W-3:0] row;
    logic [ROW_W-1:0] addr;
    logic [7:0]       wdata;

    always_comb
    begin
        // byte index within the element that lands in this lane
        ofs    = LANE_ID - acc.base[2:0];
        active = ({1'b0, ofs} < acc.n);
        pos    = {1'b0, acc.base} + (POS_W + 1)'(ofs);
        row    = pos[POS_W:3];
        addr   = row[ROW_W-1:0];
        wdata  = push_value[8*ofs +: 8];
    end

    bsmw_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .en    (acc.en & active),
        .we    (acc.we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (lane_byte)
    );

endmodule

[hw/rtl/bsmw_merge.sv]
// ----------------------------------------------------------------------------
// bsmw_merge
// Rotates the lane read bytes back into element order, zeroes unused bytes.
// ----------------------------------------------------------------------------
module bsmw_merge
    import bsmw_pkg::*;
(
    input  logic [LANES-1:0][7:0] lane_bytes,
    input  logic [2:0]            base_lo,
    input  logic [SIZE_W-1:0]     n,
    input  logic                  rd,
    output logic [63:0]           read_value
);

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (rd && (SIZE_W'(i) < n))
            begin
                read_value[8*i +: 8] = lane_bytes[3'(base_lo + 3'(i))];
            end
            else
            begin
                read_value[8*i +: 8] = 8'd0;
            end
        end
    end

endmodule

[hw/rtl/byte_stack_multi_width_core.sv]
// ----------------------------------------------------------------------------
// byte_stack_multi_width_core
// Byte-addressed stack with 1/2/4/8-byte little-endian push/pop/peek/clear.
// Lane RAMs and first stage register each request, then the output register.
// Throughput: one request per cycle while not stalled; eight byte-lane RAMs
// are read/written in the accept cycle; only the fill count spans requests.
// Reset: fill count and pipeline valids clear; store contents are undefined
// until written, with no clearing pass.
// ----------------------------------------------------------------------------
module byte_stack_multi_width_core
    import bsmw_pkg::*;
#(
    parameter int STORE_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [1:0]  size_code,
    input  logic [63:0] push_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] read_value,
    output logic [6:0]  fill_after,
    output logic [1:0]  status
);

    localparam int FILL_W = $clog2(STORE_BYTES + 1);
    localparam int ROWS   = (STORE_BYTES + 7) / 8;

    logic [FILL_W-1:0] fill_reg, fill_next;

    // request decode
    logic [SIZE_W-1:0] n;
    logic [FILL_W-1:0] n_f;
    logic [FILL_W:0]   sum;
    logic              over;
    logic              under;
    logic [FILL_W-1:0] base;
    logic              do_read;
    logic              do_write;
    logic [1:0]        st;
    logic              in_acc;
    bsmw_acc_t         acc;

    // first stage: RAM access in flight
    logic              p1_valid_reg;
    logic              p1_rd_reg;
    logic [2:0]        p1_base_reg;
    logic [SIZE_W-1:0] p1_n_reg;
    logic [6:0]        p1_fill_reg;
    logic [1:0]        p1_status_reg;
    logic              p1_adv;

    // output register
    logic              out_valid_reg;
    logic [63:0]       out_value_reg;
    logic [6:0]        out_fill_reg;
    logic [1:0]        out_status_reg;

    logic [LANES-1:0][7:0] lane_bytes;
    logic [63:0]           merged;

    assign p1_adv   = p1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = p1_valid_reg && !p1_adv;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        n        = SIZE_W'(4'd1 << size_code);
        n_f      = FILL_W'(n);
        sum      = {1'b0, fill_reg} + (FILL_W + 1)'(n);
        over     = (sum > (FILL_W + 1)'(STORE_BYTES));
        under    = (fill_reg < n_f);
        fill_next = fill_reg;
        base     = '0;
        do_read  = 1'b0;
        do_write = 1'b0;
        st       = ST_OK;
        unique case (cmd_t'(command))
            CMD_PUSH:
            begin
                do_write = 1'b1;
                if (over)
                begin
                    st        = ST_OVERFLOW;
                    fill_next = n_f;
                end
                else
                begin
                    base      = fill_reg;
                    fill_next = sum[FILL_W-1:0];
                end
            end
            CMD_POP:
            begin
                if (under)
                begin
                    st = ST_UNDERFLOW;
                end
                else
                begin
                    do_read   = 1'b1;
                    base      = fill_reg - n_f;
                    fill_next = fill_reg - n_f;
                end
            end
            CMD_PEEK_LAST:
            begin
                if (under)
                begin
                    st = ST_UNDERFLOW;
                end
                else
                begin
                    do_read = 1'b1;
                    base    = fill_reg - n_f;
                end
            end
            CMD_PEEK_FIRST:
            begin
                if (under)
                begin
                    st = ST_UNDERFLOW;
                end
                else
                begin
                    do_read = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
            end
        endcase

        acc.en   = in_acc && (do_read || do_write);
        acc.we   = do_write;
        acc.base = POS_W'(base);
        acc.n    = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                fill_reg <= fill_next;
            end
            if (in_acc)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p1_rd_reg     <= do_read;
            p1_base_reg   <= base[2:0];
            p1_n_reg      <= n;
            p1_fill_reg   <= 7'(fill_next);
            p1_status_reg <= st;
        end
        if (p1_adv)
        begin
            out_value_reg  <= merged;
            out_fill_reg   <= p1_fill_reg;
            out_status_reg <= p1_status_reg;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        bsmw_lane #(
            .LANE (g),
            .ROWS (ROWS)
        ) u_lane (
            .clk        (clk),
            .acc        (acc),
            .push_value (push_value),
            .lane_byte  (lane_bytes[g])
        );
    end

    bsmw_merge u_merge (
        .lane_bytes (lane_bytes),
        .base_lo    (p1_base_reg),
        .n          (p1_n_reg),
        .rd         (p1_rd_reg),
        .read_value (merged)
    );

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign fill_after = out_fill_reg;
    assign status     = out_status_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(STORE_BYTES))
        else $error("fill count beyond store size");

    a_under_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && st == ST_UNDERFLOW) |=> fill_reg == $past(fill_reg))
        else $error("refused request changed fill count");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> read_value == 64'd0)
        else $error("nonzero data on overflow or underflow result");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("request taken while pipeline blocked");
`endif

endmodule

[bench/byte_stack_multi_width_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stack_multi_width_core_tb
// Drives push, pop, peek and clear requests of 1/2/4/8 bytes into the byte
// stack. Keeps a shadow copy of the store and fill count, and compares every
// result against it in order. Both sides idle at random; the receiver also
// holds off once for a long stretch to back up the pipeline.
// ----------------------------------------------------------------------------
module byte_stack_multi_width_core_tb;
    import bsmw_pkg::*;

    localparam int STACK_BYTES = 64;
    localparam int RANDOM_REQS = 1200;
    localparam int CYCLE_LIMIT = 60000;
    localparam int HOLDOFF_CYCLES = 200;

    typedef struct {
        cmd_t        command;
        logic [1:0]  size_code;
        logic [63:0] push_value;
        bit          drain_first;   // hold this request until no result is outstanding
    } stack_req_t;

    typedef struct {
        logic [63:0] read_value;
        logic [6:0]  fill_after;
        logic [1:0]  status;
    } stack_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  command = '0;
    logic [1:0]  size_code = '0;
    logic [63:0] push_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] read_value;
    logic [6:0]  fill_after;
    logic [1:0]  status;

    stack_req_t  req_queue[$];
    stack_resp_t pending_results[$];
    stack_req_t  offered;
    stack_resp_t want;

    logic [7:0]  shadow_bytes [STACK_BYTES];
    int unsigned shadow_fill = 0;

    int          reqs_accepted = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          holdoff_left = 0;
    bit          holdoff_started = 0;
    logic        quiet;

    // no idling on either side through this window
    assign quiet = (reqs_accepted >= 700) && (reqs_accepted < 900);

    byte_stack_multi_width_core #(
        .STORE_BYTES(STACK_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .size_code (size_code),
        .push_value(push_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_value(read_value),
        .fill_after(fill_after),
        .status    (status)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic stack_resp_t apply_stack_request(stack_req_t r);
        stack_resp_t res;
        int unsigned nbytes;
        int unsigned base;
        nbytes = 1 << r.size_code;
        res.read_value = '0;
        res.status = ST_OK;
        base = 0;
        case (r.command)
            CMD_PUSH:
            begin
                if (shadow_fill + nbytes > STACK_BYTES)
                begin
                    shadow_fill = 0;
                    res.status = ST_OVERFLOW;
                end
                for (int i = 0; i < nbytes; i++)
                    shadow_bytes[shadow_fill + i] = r.push_value[8*i +: 8];
                shadow_fill += nbytes;
            end
            CMD_POP, CMD_PEEK_LAST, CMD_PEEK_FIRST:
            begin
                if (shadow_fill < nbytes)
                    res.status = ST_UNDERFLOW;
                else
                begin
                    if (r.command != CMD_PEEK_FIRST)
                        base = shadow_fill - nbytes;
                    for (int i = 0; i < nbytes; i++)
                        res.read_value[8*i +: 8] = shadow_bytes[base + i];
                    if (r.command == CMD_POP)
                        shadow_fill -= nbytes;
                end
            end
            CMD_CLEAR:
                shadow_fill = 0;
            default:
                ;
        endcase
        res.fill_after = shadow_fill[6:0];
        return res;
    endfunction

    task automatic queue_request(cmd_t c, logic [1:0] code, logic [63:0] v, bit drain);
        stack_req_t r;
        r.command = c;
        r.size_code = code;
        r.push_value = v;
        r.drain_first = drain;
        req_queue.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= '0;
            size_code <= '0;
            push_value <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(apply_stack_request(offered));
                reqs_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (req_queue.size() != 0
                    && !(req_queue[0].drain_first && pending_results.size() != 0)
                    && (quiet || $urandom_range(99) >= 14))
                begin
                    offered = req_queue.pop_front();
                    command <= offered.command;
                    size_code <= offered.size_code;
                    push_value <= offered.push_value;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, got %h", want.read_value, read_value);
                        mismatches++;
                    end
                    if (fill_after !== want.fill_after)
                    begin
                        $error("fill_after: expected %0d, got %0d", want.fill_after, fill_after);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                end
            end
            if (!holdoff_started && reqs_accepted >= 300)
            begin
                holdoff_started = 1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 14);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("byte_stack_multi_width_core_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int          pick;
        int          push_pct;
        int          pop_pct;
        int          peek_pct;
        bit          push_heavy;
        cmd_t        c;
        logic [63:0] v;

        // underflow on an empty stack
        queue_request(CMD_POP,        2'd0, 64'd0, 0);
        queue_request(CMD_PEEK_LAST,  2'd3, 64'd0, 0);
        queue_request(CMD_PEEK_FIRST, 2'd1, 64'd0, 0);
        // one of each width, 15 bytes held
        queue_request(CMD_PUSH, 2'd0, '1, 0);
        queue_request(CMD_PUSH, 2'd1, 64'd0, 0);
        queue_request(CMD_PUSH, 2'd2, 64'h0123_4567_89ab_cdef, 0);
        queue_request(CMD_PUSH, 2'd3, '1, 0);
        queue_request(CMD_PEEK_LAST,  2'd3, 64'd0, 0);
        queue_request(CMD_PEEK_FIRST, 2'd3, 64'd0, 0);
        queue_request(CMD_POP, 2'd3, 64'd0, 0);
        queue_request(CMD_POP, 2'd2, 64'd0, 0);
        queue_request(CMD_POP, 2'd1, 64'd0, 0);
        queue_request(CMD_POP, 2'd1, 64'd0, 0);   // one byte left, two asked
        queue_request(CMD_POP, 2'd0, 64'd0, 0);
        // clear a non-empty stack
        queue_request(CMD_PUSH,  2'd3, 64'hfedc_ba98_7654_3210, 0);
        queue_request(CMD_CLEAR, 2'd2, 64'd0, 0);
        // exact fill, then overflow
        for (int i = 0; i < STACK_BYTES / 8; i++)
            queue_request(CMD_PUSH, 2'd3, {$urandom, $urandom}, 0);
        queue_request(CMD_PUSH, 2'd0, 64'h5a, 0);
        queue_request(CMD_PEEK_FIRST, 2'd0, 64'd0, 0);

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i % 100 == 0)
                push_heavy = $urandom_range(1);
            push_pct = push_heavy ? 50 : 35;
            pop_pct  = push_heavy ? 20 : 45;
            peek_pct = push_heavy ? 12 : 8;
            pick = $urandom_range(99);
            if (pick < push_pct)
                c = CMD_PUSH;
            else if (pick < push_pct + pop_pct)
                c = CMD_POP;
            else if (pick < push_pct + pop_pct + peek_pct)
                c = CMD_PEEK_LAST;
            else if (pick < push_pct + pop_pct + 2 * peek_pct)
                c = CMD_PEEK_FIRST;
            else
                c = CMD_CLEAR;
            case ($urandom_range(9))
                0: v = '0;
                1: v = '1;
                default: v = {$urandom, $urandom};
            endcase
            queue_request(c, 2'($urandom_range(3)), v, i == 0 || i == 550);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (req_queue.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (8) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("byte_stack_multi_width_core_tb: PASS");
        else
            $display("byte_stack_multi_width_core_tb: FAIL");
        $finish;
    end

endmodule
